@@ rtl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsd_parser, wsd_out_reg and the top level.
package wsd_pkg;

    localparam int unsigned MAX_W       = 31;
    localparam int unsigned LEN_W       = 64;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned CNT_W       = 4;

    localparam logic [MAX_W-1:0] MAX_PAYLOAD_RESET = 31'd65535;
    localparam logic [6:0]       LEN7_EXT16        = 7'd126;
    localparam logic [6:0]       LEN7_EXT64        = 7'd127;
    localparam logic [CNT_W-1:0] EXT16_LAST        = 4'd1;
    localparam logic [CNT_W-1:0] EXT64_LAST        = 4'd7;
    localparam logic [CNT_W-1:0] MASK_LAST         = 4'd3;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_TOOLONG = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic        final_fragment;
        logic        end_of_frame;
    } t_result;

endpackage

@@ rtl/wsd_if.sv @@
// Valid/ready channel interfaces for the deframer: input bytes and results.
// Depends on nothing; used by the top level, wsd_in_reg and wsd_out_reg.
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       end_of_frame;

    modport source (output valid, output kind, output payload_byte, output frame_opcode,
                    output final_fragment, output end_of_frame, input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_opcode,
                    input final_fragment, input end_of_frame, output ready);
endinterface

@@ rtl/wsd_in_reg.sv @@
// Input register of the deframer: holds one received word until parsed.
// Depends on wsd_byte_if.
module wsd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsd_byte_if.sink   i_in,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.data_byte;
        end
    end

endmodule

@@ rtl/wsd_parser.sv @@
// Frame header parser and payload unmasker; holds the frame state and max_payload.
// Depends on wsd_pkg.
module wsd_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wsd_pkg::MAX_W-1:0] i_cfg_data,
    input  logic                      i_step,
    input  logic [7:0]                i_byte,
    output logic                      o_res_valid,
    output wsd_pkg::t_result          o_res
);

    wsd_pkg::t_phase              r_phase, n_phase;
    logic [wsd_pkg::MAX_W-1:0]    r_max;
    logic [3:0]                   r_opcode, n_opcode;
    logic                         r_fin, n_fin;
    logic                         r_masked, n_masked;
    logic                         r_ext64, n_ext64;
    logic [wsd_pkg::CNT_W-1:0]    r_count, n_count;
    logic [wsd_pkg::KEY_W-1:0]    r_key, n_key;
    logic [wsd_pkg::LEN_W-1:0]    r_length, n_length;
    logic [1:0]                   r_kidx, n_kidx;
    logic                         r_discard, n_discard;

    logic [6:0]                   len7;
    logic                         len_ext;
    logic                         ext_last;
    logic [wsd_pkg::LEN_W-1:0]    hdr_len;
    logic                         hdr_done;
    logic                         too_long;
    logic                         len_zero;
    logic                         eof;
    logic [7:0]                   key_byte;
    wsd_pkg::t_phase              done_phase;

    assign len7     = i_byte[6:0];
    assign len_ext  = (len7 == wsd_pkg::LEN7_EXT16) || (len7 == wsd_pkg::LEN7_EXT64);
    assign ext_last = (r_count == (r_ext64 ? wsd_pkg::EXT64_LAST : wsd_pkg::EXT16_LAST));
    assign eof      = (r_length == {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1});

    always_comb begin
        unique case (r_phase)
            wsd_pkg::PH_SECOND: hdr_len = {{(wsd_pkg::LEN_W-7){1'b0}}, len7};
            wsd_pkg::PH_EXTLEN: hdr_len = {r_length[wsd_pkg::LEN_W-9:0], i_byte};
            default:            hdr_len = r_length;
        endcase
    end

    assign too_long = hdr_len > {{(wsd_pkg::LEN_W-wsd_pkg::MAX_W){1'b0}}, r_max};
    assign len_zero = (hdr_len == '0);

    always_comb begin
        unique case (r_phase)
            wsd_pkg::PH_SECOND: hdr_done = !len_ext && !i_byte[7];
            wsd_pkg::PH_EXTLEN: hdr_done = ext_last && !r_masked;
            wsd_pkg::PH_MASK:   hdr_done = (r_count == wsd_pkg::MASK_LAST);
            default:            hdr_done = 1'b0;
        endcase
    end

    assign done_phase = (len_zero) ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;

    always_comb begin
        case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        if (!r_masked) begin
            key_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            wsd_pkg::PH_FIRST: begin
                n_phase = wsd_pkg::PH_SECOND;
            end
            wsd_pkg::PH_SECOND: begin
                if (len_ext) begin
                    n_phase = wsd_pkg::PH_EXTLEN;
                end else if (i_byte[7]) begin
                    n_phase = wsd_pkg::PH_MASK;
                end else begin
                    n_phase = done_phase;
                end
            end
            wsd_pkg::PH_EXTLEN: begin
                if (ext_last) begin
                    n_phase = r_masked ? wsd_pkg::PH_MASK : done_phase;
                end
            end
            wsd_pkg::PH_MASK: begin
                if (hdr_done) begin
                    n_phase = done_phase;
                end
            end
            wsd_pkg::PH_PAYLOAD: begin
                if (eof) begin
                    n_phase = wsd_pkg::PH_FIRST;
                end
            end
            default: n_phase = wsd_pkg::PH_FIRST;
        endcase
    end

    // outputs and frame registers
    always_comb begin
        n_opcode  = r_opcode;
        n_fin     = r_fin;
        n_masked  = r_masked;
        n_ext64   = r_ext64;
        n_count   = r_count;
        n_key     = r_key;
        n_length  = r_length;
        n_kidx    = r_kidx;
        n_discard = r_discard;

        o_res_valid          = 1'b0;
        o_res.kind           = wsd_pkg::KIND_DATA;
        o_res.payload_byte   = 8'h00;
        o_res.frame_opcode   = r_opcode;
        o_res.final_fragment = r_fin;
        o_res.end_of_frame   = 1'b1;

        unique case (r_phase)
            wsd_pkg::PH_FIRST: begin
                n_fin    = i_byte[7];
                n_opcode = i_byte[3:0];
            end
            wsd_pkg::PH_SECOND: begin
                n_masked = i_byte[7];
                n_count  = '0;
                n_ext64  = (len7 == wsd_pkg::LEN7_EXT64);
                n_length = len_ext ? '0 : hdr_len;
            end
            wsd_pkg::PH_EXTLEN: begin
                n_length = hdr_len;
                n_count  = ext_last ? '0 : r_count + 1'b1;
            end
            wsd_pkg::PH_MASK: begin
                n_key   = {r_key[wsd_pkg::KEY_W-9:0], i_byte};
                n_count = r_count + 1'b1;
            end
            wsd_pkg::PH_PAYLOAD: begin
                o_res_valid        = !r_discard;
                o_res.payload_byte = i_byte ^ key_byte;
                o_res.end_of_frame = eof;
                n_length           = r_length - 1'b1;
                n_kidx             = r_kidx + 1'b1;
                if (eof) begin
                    n_discard = 1'b0;
                end
            end
            default: begin
            end
        endcase

        if (hdr_done) begin
            n_kidx    = '0;
            n_discard = too_long;
            if (too_long) begin
                o_res_valid = 1'b1;
                o_res.kind  = wsd_pkg::KIND_TOOLONG;
            end else if (len_zero) begin
                o_res_valid = 1'b1;
                o_res.kind  = wsd_pkg::KIND_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wsd_pkg::PH_FIRST;
            r_discard <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_discard <= n_discard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= wsd_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_ext64  <= n_ext64;
            r_count  <= n_count;
            r_key    <= n_key;
            r_length <= n_length;
            r_kidx   <= n_kidx;
        end
    end

endmodule

@@ rtl/wsd_out_reg.sv @@
// Result register of the deframer: holds one result word for the sink.
// Depends on wsd_pkg and wsd_res_if.
module wsd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsd_pkg::t_result i_res,
    output logic             o_free,
    wsd_res_if.source        o_out
);

    logic             r_valid;
    wsd_pkg::t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_res.kind;
    assign o_out.payload_byte   = r_res.payload_byte;
    assign o_out.frame_opcode   = r_res.frame_opcode;
    assign o_out.final_fragment = r_res.final_fragment;
    assign o_out.end_of_frame   = r_res.end_of_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// Top level of the WebSocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_if, wsd_in_reg, wsd_parser and wsd_out_reg.
//
//   channel   dir  width  payload
//   i_in      in   8      data_byte
//   o_out     out  16     kind, payload_byte, frame_opcode, final_fragment, end_of_frame
//   i_cfg_*   in   31     max_payload
//
// One word per cycle sustained while o_out.ready stays high; a word is held in the input register
// and its result, if any, is loaded into the result register when the parser takes the word.
// Synchronous active-low reset; max_payload returns to 65535.
// A stalled result holds the result register and, through it, the input register;
// i_in.ready drops only while both are full.
module websocket_frame_deframer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wsd_pkg::MAX_W-1:0] i_cfg_data,
    wsd_byte_if.sink                  i_in,
    wsd_res_if.source                 o_out
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             out_free;
    logic             step;
    logic             res_valid;
    wsd_pkg::t_result res;

    assign step = in_valid && out_free;

    wsd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (step),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule
